// ===== rtl/usm_pkg.sv =====
// Shared types, codes and constants of the UV sphere mesh generator.
// Used by every module of the block but usm_div; depends on nothing.
package usm_pkg;

  localparam int MAX_DIVISIONS_DEF = 256;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STEPS      = 30;
  localparam int CW                = 34;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
  localparam int QDEPTH            = 4;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_BANDS  = 2'd1;
  localparam logic [1:0] REG_SEGS   = 2'd2;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_TRI    = 2'd1;
  localparam logic [1:0] KIND_OOR    = 2'd2;

  typedef enum logic [2:0] {
    CLS_RING, CLS_TOP, CLS_BOT, CLS_CAP, CLS_BAND, CLS_FAN, CLS_OOR
  } cls_t;

  typedef struct packed {
    logic [8:0]  bands;
    logic [8:0]  segs;
    logic [15:0] radius;
    logic [15:0] vtot;
    logic [15:0] vlast;
    logic [18:0] itot;
    logic [16:0] ttot;
    logic [16:0] band;
    logic [15:0] obase;
  } mesh_t;

  typedef struct packed {
    cls_t        cls;
    logic [16:0] idx;
    logic [16:0] num;
  } qword_t;

  function automatic logic signed [CW-1:0] atan_turn(input int i);
    case (i)
      0:  atan_turn = 34'sd536870912;
      1:  atan_turn = 34'sd316933406;
      2:  atan_turn = 34'sd167458907;
      3:  atan_turn = 34'sd85004756;
      4:  atan_turn = 34'sd42667331;
      5:  atan_turn = 34'sd21354465;
      6:  atan_turn = 34'sd10679838;
      7:  atan_turn = 34'sd5340245;
      8:  atan_turn = 34'sd2670163;
      9:  atan_turn = 34'sd1335087;
      10: atan_turn = 34'sd667544;
      11: atan_turn = 34'sd333772;
      12: atan_turn = 34'sd166886;
      13: atan_turn = 34'sd83443;
      14: atan_turn = 34'sd41722;
      15: atan_turn = 34'sd20861;
      16: atan_turn = 34'sd10430;
      17: atan_turn = 34'sd5215;
      18: atan_turn = 34'sd2608;
      19: atan_turn = 34'sd1304;
      20: atan_turn = 34'sd652;
      21: atan_turn = 34'sd326;
      22: atan_turn = 34'sd163;
      23: atan_turn = 34'sd81;
      24: atan_turn = 34'sd41;
      25: atan_turn = 34'sd20;
      26: atan_turn = 34'sd10;
      27: atan_turn = 34'sd5;
      28: atan_turn = 34'sd3;
      29: atan_turn = 34'sd1;
      default: atan_turn = 34'sd0;
    endcase
  endfunction

endpackage

// ===== rtl/usm_front.sv =====
// Front end: input register and query classification.
// Depends on usm_pkg; feeds usm_queue.
module usm_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           req_type,
  input  logic [16:0]    item_index,
  input  usm_pkg::mesh_t mesh,
  input  logic           q_full,
  output logic           push,
  output usm_pkg::qword_t word
);
  import usm_pkg::*;

  logic        fr_valid;
  logic        fr_req;
  logic [16:0] fr_idx;
  logic [16:0] t;
  logic [16:0] seg17;

  assign in_stall = fr_valid && q_full;
  assign push     = fr_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (!in_stall) begin
      fr_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      fr_req <= req_type;
      fr_idx <= item_index;
    end
  end

  always_comb begin
    seg17    = {8'd0, mesh.segs};
    t        = fr_idx - seg17;
    word.idx = fr_idx;
    word.num = t;
    word.cls = CLS_OOR;
    if (!fr_req) begin
      if (fr_idx < {1'b0, mesh.vtot}) begin
        if (fr_idx == 17'd0) begin
          word.cls = CLS_TOP;
        end else if (fr_idx == {1'b0, mesh.vlast}) begin
          word.cls = CLS_BOT;
        end else begin
          word.cls = CLS_RING;
          word.num = fr_idx - 17'd1;
        end
      end
    end else if (fr_idx < mesh.ttot) begin
      if (fr_idx < seg17) begin
        word.cls = CLS_CAP;
      end else if (t < mesh.band) begin
        word.cls = CLS_BAND;
      end else begin
        word.cls = CLS_FAN;
      end
    end
  end

endmodule

// ===== rtl/usm_queue.sv =====
// Short queue of classified words between front and back end.
// Depends on usm_pkg.
module usm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  usm_pkg::qword_t din,
  input  logic            pop,
  output usm_pkg::qword_t dout,
  output logic            empty,
  output logic            full
);
  import usm_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CNW = $clog2(QDEPTH + 1);

  qword_t          mem [QDEPTH];
  logic [PW-1:0]   wp;
  logic [PW-1:0]   rp;
  logic [CNW-1:0]  cnt;

  assign empty = (cnt == CNW'(0));
  assign full  = (cnt == CNW'(QDEPTH));
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + PW'(1);
      end
      if (pop) begin
        rp <= rp + PW'(1);
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + CNW'(1);
        2'b01:   cnt <= cnt - CNW'(1);
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ===== rtl/usm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; used by usm_back.
module usm_div #(
  parameter int DW = 17,
  parameter int VW = 10
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] num,
  input  logic [VW-1:0] den,
  output logic [DW-1:0] quo,
  output logic [VW-1:0] rem
);

  logic [DW-1:0] a [DW];
  logic [VW-1:0] r [DW];
  logic [VW-1:0] d [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [DW-1:0] a_in;
    logic [VW-1:0] r_in;
    logic [VW-1:0] d_in;
    logic [VW:0]   sh;
    logic [VW:0]   df;
    logic          ge;

    if (k == 0) begin : g_first
      assign a_in = num;
      assign r_in = '0;
      assign d_in = den;
    end else begin : g_next
      assign a_in = a[k-1];
      assign r_in = r[k-1];
      assign d_in = d[k-1];
    end

    assign sh = {r_in, a_in[DW-1]};
    assign ge = (sh >= {1'b0, d_in});
    assign df = sh - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        a[k] <= {a_in[DW-2:0], ge};
        r[k] <= ge ? df[VW-1:0] : sh[VW-1:0];
        d[k] <= d_in;
      end
    end
  end

  assign quo = a[DW-1];
  assign rem = r[DW-1];

endmodule

// ===== rtl/usm_cordic.sv =====
// Pipelined rotation CORDIC with quadrant fold, one step per stage.
// Depends on usm_pkg for the arctangent table; used by usm_back.
module usm_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        phase,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import usm_pkg::*;

  logic signed [CW-1:0] x  [CORDIC_STEPS];
  logic signed [CW-1:0] y  [CORDIC_STEPS];
  logic signed [CW-1:0] z  [CORDIC_STEPS];
  logic [1:0]           qd [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [CW-1:0] z_in;
    logic [1:0]           q_in;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    if (i == 0) begin : g_first
      assign x_in = CORDIC_X0;
      assign y_in = '0;
      assign z_in = $signed({{(CW-30){1'b0}}, phase[29:0]});
      assign q_in = phase[31:30];
    end else begin : g_next
      assign x_in = x[i-1];
      assign y_in = y[i-1];
      assign z_in = z[i-1];
      assign q_in = qd[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        qd[i] <= q_in;
        if (!z_in[CW-1]) begin
          x[i] <= x_in - dx;
          y[i] <= y_in + dy;
          z[i] <= z_in - atan_turn(i);
        end else begin
          x[i] <= x_in + dx;
          y[i] <= y_in - dy;
          z[i] <= z_in + atan_turn(i);
        end
      end
    end
  end

  logic signed [CW-1:0] xl;
  logic signed [CW-1:0] yl;
  logic signed [CW-1:0] nxl;
  logic signed [CW-1:0] nyl;

  assign xl  = x[CORDIC_STEPS-1];
  assign yl  = y[CORDIC_STEPS-1];
  assign nxl = -xl;
  assign nyl = -yl;

  always_ff @(posedge clk) begin
    if (en) begin
      case (qd[CORDIC_STEPS-1])
        2'd0: begin
          cos_o <= xl[31:0];
          sin_o <= yl[31:0];
        end
        2'd1: begin
          cos_o <= nyl[31:0];
          sin_o <= xl[31:0];
        end
        2'd2: begin
          cos_o <= nxl[31:0];
          sin_o <= nyl[31:0];
        end
        default: begin
          cos_o <= yl[31:0];
          sin_o <= nxl[31:0];
        end
      endcase
    end
  end

endmodule

// ===== rtl/usm_back.sv =====
// Back end: index division, angle division, CORDIC and fixed-point scaling.
// Depends on usm_pkg, usm_div and usm_cordic; drains usm_queue.
module usm_back #(
  parameter int ANGLE_BITS = usm_pkg::ANGLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  usm_pkg::mesh_t      mesh,
  input  logic                q_empty,
  input  usm_pkg::qword_t     q_word,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          result_kind,
  output logic [15:0]         corner_a,
  output logic [15:0]         corner_b,
  output logic [15:0]         corner_c,
  output logic signed [16:0]  pos_x,
  output logic signed [16:0]  pos_y,
  output logic signed [16:0]  pos_z,
  output logic signed [15:0]  norm_x,
  output logic signed [15:0]  norm_y,
  output logic signed [15:0]  norm_z
);
  import usm_pkg::*;

  localparam int DW1 = 17;
  localparam int VW1 = 10;
  localparam int DW2 = 9 + ANGLE_BITS;
  localparam int LB  = DW2 + CORDIC_STEPS + 1;

  typedef struct packed {
    cls_t        cls;
    logic [16:0] idx;
  } sa_t;

  typedef struct packed {
    cls_t        cls;
    logic [15:0] ca;
    logic [15:0] cb;
    logic [15:0] cc;
  } sb_t;

  logic adv;
  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && !q_empty;

  // index division
  logic [VW1-1:0] den1;
  logic [DW1-1:0] quo1;
  logic [VW1-1:0] rem1;
  sa_t            sa_in;
  sa_t            dl_a [DW1];
  logic [DW1-1:0] vl_a;

  assign den1      = (q_word.cls == CLS_BAND) ? {mesh.segs, 1'b0} : {1'b0, mesh.segs};
  assign sa_in.cls = q_word.cls;
  assign sa_in.idx = q_word.idx;

  usm_div #(.DW(DW1), .VW(VW1)) u_div_idx (
    .clk(clk), .en(adv), .num(q_word.num), .den(den1), .quo(quo1), .rem(rem1)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_a[0] <= sa_in;
      for (int k = 1; k < DW1; k++) begin
        dl_a[k] <= dl_a[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vl_a <= '0;
    end else if (adv) begin
      vl_a <= {vl_a[DW1-2:0], !q_empty};
    end
  end

  // corners, ring and segment
  sa_t         sa;
  sb_t         sb_next;
  logic [16:0] seg17;
  logic [16:0] kmul;
  logic [16:0] it;
  logic [16:0] ot;
  logic [16:0] jt;
  logic [16:0] oi;
  logic [16:0] oj;
  logic [16:0] ois;
  logic [16:0] ojs;

  always_comb begin
    sa    = dl_a[DW1-1];
    seg17 = {8'd0, mesh.segs};
    kmul  = {8'd0, quo1[8:0]} * seg17;
    it    = '0;
    ot    = 17'd1;
    case (sa.cls)
      CLS_CAP: begin
        it = sa.idx;
      end
      CLS_BAND: begin
        it = {8'd0, rem1[9:1]};
        ot = 17'd1 + kmul;
      end
      CLS_FAN: begin
        it = sa.idx - seg17 - mesh.band;
        ot = {1'b0, mesh.obase};
      end
      default: begin
        it = '0;
      end
    endcase
    jt  = (it + 17'd1 == seg17) ? 17'd0 : it + 17'd1;
    oi  = ot + it;
    oj  = ot + jt;
    ois = oi + seg17;
    ojs = oj + seg17;
    sb_next.cls = sa.cls;
    sb_next.ca  = '0;
    sb_next.cb  = '0;
    sb_next.cc  = '0;
    case (sa.cls)
      CLS_CAP: begin
        sb_next.cb = oi[15:0];
        sb_next.cc = oj[15:0];
      end
      CLS_BAND: begin
        if (!rem1[0]) begin
          sb_next.ca = oi[15:0];
          sb_next.cb = ois[15:0];
          sb_next.cc = oj[15:0];
        end else begin
          sb_next.ca = oj[15:0];
          sb_next.cb = ois[15:0];
          sb_next.cc = ojs[15:0];
        end
      end
      CLS_FAN: begin
        sb_next.ca = oi[15:0];
        sb_next.cb = mesh.vlast;
        sb_next.cc = oj[15:0];
      end
      default: begin
        sb_next.ca = '0;
      end
    endcase
  end

  sb_t        sb;
  logic       vb;
  logic [8:0] ring_b;
  logic [8:0] seg_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      sb     <= sb_next;
      ring_b <= quo1[8:0] + 9'd1;
      seg_b  <= rem1[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (adv) begin
      vb <= vl_a[DW1-1];
    end
  end

  // angle division and trig
  logic [DW2-1:0] num_r;
  logic [DW2-1:0] num_s;
  logic [DW2-1:0] quo_r;
  logic [DW2-1:0] quo_s;
  logic [8:0]     rem_r;
  logic [8:0]     rem_s;
  logic [31:0]    ph_r;
  logic [31:0]    ph_s;

  assign num_r = {1'b0, ring_b, {(ANGLE_BITS-1){1'b0}}};
  assign num_s = {seg_b, {ANGLE_BITS{1'b0}}};

  usm_div #(.DW(DW2), .VW(9)) u_div_ring (
    .clk(clk), .en(adv), .num(num_r), .den(mesh.bands), .quo(quo_r), .rem(rem_r)
  );

  usm_div #(.DW(DW2), .VW(9)) u_div_seg (
    .clk(clk), .en(adv), .num(num_s), .den(mesh.segs), .quo(quo_s), .rem(rem_s)
  );

  logic unused_rem;
  assign unused_rem = ^{rem_r, rem_s, quo_r[DW2-1:ANGLE_BITS], quo_s[DW2-1:ANGLE_BITS]};

  assign ph_r = {quo_r[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
  assign ph_s = {quo_s[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};

  logic signed [31:0] cr;
  logic signed [31:0] sr;
  logic signed [31:0] cs;
  logic signed [31:0] ss;

  usm_cordic u_cordic_ring (.clk(clk), .en(adv), .phase(ph_r), .cos_o(cr), .sin_o(sr));
  usm_cordic u_cordic_seg  (.clk(clk), .en(adv), .phase(ph_s), .cos_o(cs), .sin_o(ss));

  sb_t           dl_b [LB];
  logic [LB-1:0] vl_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_b[0] <= sb;
      for (int k = 1; k < LB; k++) begin
        dl_b[k] <= dl_b[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vl_b <= '0;
    end else if (adv) begin
      vl_b <= {vl_b[LB-2:0], vb && !unused_rem || vb};
    end
  end

  // products, rounding and scaling
  sb_t                sm1;
  sb_t                sm2;
  sb_t                sm3;
  logic [2:0]         vm;
  logic signed [63:0] px;
  logic signed [63:0] py;
  logic signed [31:0] crr;
  logic signed [15:0] nx2;
  logic signed [15:0] ny2;
  logic signed [15:0] nz2;
  logic signed [15:0] nx3;
  logic signed [15:0] ny3;
  logic signed [15:0] nz3;
  logic signed [32:0] ppx;
  logic signed [32:0] ppy;
  logic signed [32:0] ppz;

  logic signed [63:0] rx;
  logic signed [63:0] ry;
  logic signed [32:0] rz;
  logic signed [18:0] qx;
  logic signed [18:0] qy;
  logic signed [17:0] qz;
  logic signed [16:0] rad17;

  assign rx    = px + (64'sd1 <<< 44);
  assign ry    = py + (64'sd1 <<< 44);
  assign rz    = {crr[31], crr} + 33'sd16384;
  assign qx    = rx[63:45];
  assign qy    = ry[63:45];
  assign qz    = rz[32:15];
  assign rad17 = $signed({1'b0, mesh.radius});

  function automatic logic signed [15:0] sat_n(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      sat_n = 16'sd32767;
    end else if (v < -19'sd32768) begin
      sat_n = -16'sd32768;
    end else begin
      sat_n = v[15:0];
    end
  endfunction

  function automatic logic signed [16:0] sat_p(input logic signed [32:0] v);
    logic signed [32:0] rv;
    logic signed [17:0] q;
    rv = v + 33'sd16384;
    q  = rv[32:15];
    if (q > 18'sd65535) begin
      sat_p = 17'sd65535;
    end else if (q < -18'sd65535) begin
      sat_p = -17'sd65535;
    end else begin
      sat_p = q[16:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      sm1 <= dl_b[LB-1];
      px  <= sr * cs;
      py  <= sr * ss;
      crr <= cr;
      sm2 <= sm1;
      nx2 <= sat_n(qx);
      ny2 <= sat_n(qy);
      nz2 <= sat_n({qz[17], qz});
      sm3 <= sm2;
      nx3 <= nx2;
      ny3 <= ny2;
      nz3 <= nz2;
      ppx <= nx2 * rad17;
      ppy <= ny2 * rad17;
      ppz <= nz2 * rad17;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm        <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vm        <= {vm[1:0], vl_b[LB-1]};
      out_valid <= vm[2];
    end
  end

  // output word
  logic signed [16:0] rpos;
  assign rpos = rad17;

  always_ff @(posedge clk) begin
    if (adv) begin
      result_kind <= KIND_OOR;
      corner_a    <= '0;
      corner_b    <= '0;
      corner_c    <= '0;
      pos_x       <= '0;
      pos_y       <= '0;
      pos_z       <= '0;
      norm_x      <= '0;
      norm_y      <= '0;
      norm_z      <= '0;
      case (sm3.cls)
        CLS_RING: begin
          result_kind <= KIND_VERTEX;
          pos_x       <= sat_p(ppx);
          pos_y       <= sat_p(ppy);
          pos_z       <= sat_p(ppz);
          norm_x      <= nx3;
          norm_y      <= ny3;
          norm_z      <= nz3;
        end
        CLS_TOP: begin
          result_kind <= KIND_VERTEX;
          pos_z       <= rpos;
          norm_z      <= 16'sd32767;
        end
        CLS_BOT: begin
          result_kind <= KIND_VERTEX;
          pos_z       <= -rpos;
          norm_z      <= -16'sd32768;
        end
        CLS_CAP, CLS_BAND, CLS_FAN: begin
          result_kind <= KIND_TRI;
          corner_a    <= sm3.ca;
          corner_b    <= sm3.cb;
          corner_c    <= sm3.cc;
        end
        default: begin
          result_kind <= KIND_OOR;
        end
      endcase
    end
  end

endmodule

// ===== rtl/uv_sphere_mesh_generator.sv =====
// UV sphere mesh generator: answers vertex and triangle queries on a UV sphere.
// Depends on usm_pkg, usm_front, usm_queue and usm_back.
//
// Input channel: in_valid/in_stall with req_type (0 vertex, 1 triangle) and
// item_index. A word is taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall; one result word per query, in order,
// carrying result_kind, corners, position and normal, beside both mesh counts.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index 0 radius,
// 1 latitude bands, 2 longitude segments; cfg_ready is always high, other
// indexes are dropped. Write only while no query is in flight.
// The path from accept to out_valid runs through the 17-stage index divider,
// the (9 + ANGLE_BITS)-stage angle dividers, the 31-stage CORDIC and the
// product and scaling stages.
// Throughput: one query per cycle while out_stall is low; every unit is fully pipelined.
// When out_stall is high while out_valid is set the back end holds; the queue
// and input register then absorb five more words before in_stall rises.
// Reset (rst, synchronous) empties the pipeline and queue and loads radius 256,
// 16 bands and 16 segments.
module uv_sphere_mesh_generator #(
  parameter int MAX_DIVISIONS = usm_pkg::MAX_DIVISIONS_DEF,
  parameter int ANGLE_BITS    = usm_pkg::ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [16:0]        item_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         result_kind,
  output logic [15:0]        corner_a,
  output logic [15:0]        corner_b,
  output logic [15:0]        corner_c,
  output logic signed [16:0] pos_x,
  output logic signed [16:0] pos_y,
  output logic signed [16:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic [15:0]        vertex_total,
  output logic [18:0]        index_total,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import usm_pkg::*;

  localparam logic [8:0] MAXD = 9'(MAX_DIVISIONS);

  logic [15:0] radius;
  logic [8:0]  lat_bands;
  logic [8:0]  lon_segments;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= 16'd256;
      lat_bands    <= 9'd16;
      lon_segments <= 9'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RADIUS: radius       <= cfg_data;
        REG_BANDS:  lat_bands    <= cfg_data[8:0];
        REG_SEGS:   lon_segments <= cfg_data[8:0];
        default:    radius       <= radius;
      endcase
    end
  end

  logic [8:0]  b_eff;
  logic [8:0]  s_eff;
  logic [16:0] bm1;
  logic [16:0] bm2;
  logic [16:0] pv;
  logic [16:0] pb;
  mesh_t       mesh;

  assign b_eff = (lat_bands < 9'd2) ? 9'd2 : ((lat_bands > MAXD) ? MAXD : lat_bands);
  assign s_eff = (lon_segments < 9'd3) ? 9'd3 :
                 ((lon_segments > MAXD) ? MAXD : lon_segments);
  assign bm1   = {8'd0, b_eff - 9'd1};
  assign bm2   = {8'd0, b_eff - 9'd2};
  assign pv    = bm1 * {8'd0, s_eff};
  assign pb    = bm2 * {8'd0, s_eff};

  always_ff @(posedge clk) begin
    mesh.bands  <= b_eff;
    mesh.segs   <= s_eff;
    mesh.radius <= radius;
    mesh.vtot   <= pv[15:0] + 16'd2;
    mesh.vlast  <= pv[15:0] + 16'd1;
    mesh.itot   <= {pv, 2'b00} + {1'b0, pv, 1'b0};
    mesh.ttot   <= {pv[15:0], 1'b0};
    mesh.band   <= {pb[15:0], 1'b0};
    mesh.obase  <= pb[15:0] + 16'd1;
  end

  assign vertex_total = mesh.vtot;
  assign index_total  = mesh.itot;

  logic   push;
  logic   pop;
  logic   q_empty;
  logic   q_full;
  qword_t f_word;
  qword_t q_word;

  usm_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .item_index(item_index), .mesh(mesh),
    .q_full(q_full), .push(push), .word(f_word)
  );

  usm_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(f_word), .pop(pop),
    .dout(q_word), .empty(q_empty), .full(q_full)
  );

  usm_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
    .clk(clk), .rst(rst), .mesh(mesh), .q_empty(q_empty), .q_word(q_word),
    .q_pop(pop), .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .corner_a(corner_a), .corner_b(corner_b),
    .corner_c(corner_c), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z)
  );

endmodule

// ===== rtl/usm_checker.sv =====
// Port-level assertions for the UV sphere mesh generator, bound to the top level.
// Depends on usm_pkg.
module usm_props (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         result_kind,
  input logic [15:0]        corner_a,
  input logic [15:0]        corner_b,
  input logic [15:0]        corner_c,
  input logic signed [16:0] pos_x,
  input logic signed [16:0] pos_y,
  input logic signed [16:0] pos_z,
  input logic signed [15:0] norm_x,
  input logic signed [15:0] norm_y,
  input logic signed [15:0] norm_z
);
  import usm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_kind) && $stable(corner_a)
      && $stable(pos_x) && $stable(norm_z))
    else $error("result word changed under stall");

  a_tri_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_TRI |-> pos_x == 0 && pos_y == 0 && pos_z == 0
      && norm_x == 0 && norm_y == 0 && norm_z == 0)
    else $error("triangle word carries vertex data");

  a_vtx_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_VERTEX |-> corner_a == 0 && corner_b == 0
      && corner_c == 0)
    else $error("vertex word carries corners");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_OOR |-> corner_a == 0 && corner_b == 0
      && corner_c == 0 && pos_z == 0 && norm_z == 0)
    else $error("out of range word not cleared");

endmodule

bind uv_sphere_mesh_generator usm_props u_usm_props (.*);
